FILE: rtl/sswi_pkg.sv
// ----------------------------------------------------------------------------
// sswi_pkg: shared types for the stable sort with indices unit
// Cell contents and the per-cycle control word broadcast along the chain.
// ----------------------------------------------------------------------------
package sswi_pkg;

  localparam int ValueWidth = 32;
  localparam int IndexWidth = 6;

  typedef struct packed {
    logic                         vld;
    logic signed [ValueWidth-1:0] value;
    logic [IndexWidth-1:0]        idx;
  } cell_t;

  typedef struct packed {
    logic ins_en;
    logic shift_en;
  } ctrl_t;

endpackage

FILE: rtl/sswi_cell.sv
// ----------------------------------------------------------------------------
// sswi_cell: one slot of the insertion chain
// Holds one element. On insert it takes the new element or its left
// neighbor; on drain it takes its right neighbor.
// ----------------------------------------------------------------------------
module sswi_cell
  import sswi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  ctrl_t ctrl,
  input  cell_t new_elem,
  input  cell_t left,
  input  logic  left_ins,
  input  cell_t right,
  output cell_t cur,
  output logic  ins
);

  cell_t cur_next;

  // equal values stay ahead of the new one, which keeps the order stable
  assign ins = !cur.vld || (new_elem.value < cur.value);

  always_comb begin
    cur_next = cur;
    if (ctrl.ins_en) begin
      if (ins) begin
        cur_next = left_ins ? left : new_elem;
      end
    end else if (ctrl.shift_en) begin
      cur_next = right;
    end
  end

  always_ff @(posedge clk) begin
    cur.value <= cur_next.value;
    cur.idx   <= cur_next.idx;
    if (rst) begin
      cur.vld <= 1'b0;
    end else begin
      cur.vld <= cur_next.vld;
    end
  end

endmodule

FILE: rtl/stable_sort_with_indices_unit.sv
// ----------------------------------------------------------------------------
// stable_sort_with_indices_unit: stable ascending sort with original positions
// Loads a list through an insertion chain and drains it in sorted order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, value, last) takes one element per
//   beat. Each beat is placed in the chain of MAX_LEN cells as it is accepted,
//   so loading runs at one beat per cycle. Beats beyond MAX_LEN elements
//   are dropped; a dropped beat that carries last still ends the list.
//   After the last beat the input stalls and the chain drains from cell 0,
//   one result beat per cycle (sorted_value, original_index, final_res).
//   The first result is shown the cycle after the last input beat. Equal
//   values leave in load order. final_res marks the last result, after
//   which the input opens again for a new list.
//   When the receiver stalls (out_ready low) the chain holds its contents
//   and the current result stays on the output.
//   Reset clears all cell valid flags, the load count and the drain flag;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module stable_sort_with_indices_unit
  import sswi_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ValueWidth-1:0] value,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ValueWidth-1:0] sorted_value,
  output logic [IndexWidth-1:0]        original_index,
  output logic                         final_res
);

  localparam int CountWidth = $clog2(MAX_LEN + 1);

  logic                  draining;
  logic [CountWidth-1:0] load_count;
  cell_t                 cells [MAX_LEN];
  logic                  ins   [MAX_LEN];
  cell_t                 new_elem;
  ctrl_t                 ctrl;
  logic                  in_acc;
  logic                  out_acc;
  logic                  full;

  assign in_ready  = !draining;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = draining && cells[0].vld;
  assign out_acc   = out_valid && out_ready;
  assign full      = (load_count == CountWidth'(MAX_LEN));

  assign new_elem.vld   = 1'b1;
  assign new_elem.value = value;
  assign new_elem.idx   = IndexWidth'(load_count);

  assign ctrl.ins_en   = in_acc && !full;
  assign ctrl.shift_en = out_acc;

  assign sorted_value   = cells[0].value;
  assign original_index = cells[0].idx;
  assign final_res      = !cells[1].vld;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    cell_t left;
    cell_t right;
    logic  left_ins;

    if (i == 0) begin : g_head
      assign left     = '0;
      assign left_ins = 1'b0;
    end else begin : g_body
      assign left     = cells[i-1];
      assign left_ins = ins[i-1];
    end

    if (i == MAX_LEN - 1) begin : g_tail
      assign right = '0;
    end else begin : g_inner
      assign right = cells[i+1];
    end

    sswi_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .new_elem (new_elem),
      .left     (left),
      .left_ins (left_ins),
      .right    (right),
      .cur      (cells[i]),
      .ins      (ins[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining   <= 1'b0;
      load_count <= '0;
    end else begin
      if (in_acc) begin
        if (last) begin
          draining   <= 1'b1;
          load_count <= '0;
        end else if (!full) begin
          load_count <= load_count + CountWidth'(1);
        end
      end
      if (out_acc && final_res) begin
        draining <= 1'b0;
      end
    end
  end

endmodule

FILE: tb/sv/tb_stable_sort_with_indices_unit.sv
// ----------------------------------------------------------------------------
// tb_stable_sort_with_indices_unit: self-checking bench for the sort unit
// Loads lists of signed values over the input channel and checks that every
// result beat leaves in ascending order, with equal values in load order,
// the right original index and the final mark on the last beat. A scoreboard
// predicts each sorted run from the accepted input beats, including lists
// that overflow the chain. The sender and receiver idle at varying rates,
// the receiver holds off once long enough to fill the block.
// ----------------------------------------------------------------------------
module tb_stable_sort_with_indices_unit;
  import sswi_pkg::*;

  localparam int ListCap = 64;
  localparam int HoldCycles = 400;
  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 20;
  localparam int PhaseItems = 22;
  localparam logic signed [ValueWidth-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [ValueWidth-1:0] ValMax = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic [IndexWidth-1:0]        idx;
    logic                         fin;
  } sorted_beat_t;

  class sort_scoreboard;
    logic signed [ValueWidth-1:0] list_vals[$];
    sorted_beat_t                 pending_sorted[$];
    int                           errors = 0;

    function void note_element(logic signed [ValueWidth-1:0] v, logic l);
      int order[$];
      int p;
      sorted_beat_t b;
      if (list_vals.size() < ListCap) list_vals.push_back(v);
      if (!l) return;
      // insert after equal values to keep load order
      for (int i = 0; i < list_vals.size(); i++) begin
        p = 0;
        while (p < order.size() && list_vals[order[p]] <= list_vals[i]) p++;
        order.insert(p, i);
      end
      for (int k = 0; k < order.size(); k++) begin
        b.value = list_vals[order[k]];
        b.idx   = IndexWidth'(order[k]);
        b.fin   = (k == order.size() - 1);
        pending_sorted.push_back(b);
      end
      list_vals.delete();
    endfunction

    function void check_sorted(logic signed [ValueWidth-1:0] v,
                               logic [IndexWidth-1:0] idx, logic fin);
      sorted_beat_t b;
      if (pending_sorted.size() == 0) begin
        $display("%0t: unexpected result beat, sorted_value %0d original_index %0d",
                 $time, v, idx);
        errors++;
        return;
      end
      b = pending_sorted.pop_front();
      if (v !== b.value) begin
        $display("%0t: sorted_value expected %0d actual %0d", $time, b.value, v);
        errors++;
      end
      if (idx !== b.idx) begin
        $display("%0t: original_index expected %0d actual %0d", $time, b.idx, idx);
        errors++;
      end
      if (fin !== b.fin) begin
        $display("%0t: final_res expected %0b actual %0b", $time, b.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [ValueWidth-1:0] value;
  logic                         last;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [ValueWidth-1:0] sorted_value;
  logic [IndexWidth-1:0]        original_index;
  logic                         final_res;

  sort_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_req = 1'b0;
  int hold_cnt = 0;
  int cycle_count = 0;
  int sent_items;
  logic signed [ValueWidth-1:0] dir_q[$];

  stable_sort_with_indices_unit #(
    .MAX_LEN(ListCap)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .value          (value),
    .last           (last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sorted_value   (sorted_value),
    .original_index (original_index),
    .final_res      (final_res)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("stable_sort_with_indices_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_element(value, last);
    if (!rst && out_valid && out_ready) sb.check_sorted(sorted_value, original_index, final_res);
  end

  // receiver: long hold-off once on request, random stalls otherwise
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_cnt < HoldCycles) begin
        out_ready = 1'b0;
        hold_cnt++;
      end else begin
        out_ready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic logic signed [ValueWidth-1:0] rand_value();
    case ($urandom_range(9))
      0:       return ValMin;
      1:       return ValMax;
      2, 3:    return ValueWidth'(int'($urandom_range(8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(input logic signed [ValueWidth-1:0] v, input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    value    = v;
    last     = l;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic send_dir_list();
    for (int i = 0; i < dir_q.size(); i++) send_beat(dir_q[i], i == dir_q.size() - 1);
  endtask

  task automatic send_rand_list(input int len);
    for (int i = 0; i < len; i++) send_beat(rand_value(), i == len - 1);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_sorted.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input logic long_list);
    int len;
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    sent_items   = 0;
    // chain overflow: two dropped beats, then a dropped last
    if (long_list) send_rand_list(ListCap + 3);
    while (sent_items < PhaseItems) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(ListCap - 2, ListCap + 4)
                                      : $urandom_range(1, 8);
      send_rand_list(len);
    end
    wait_drain();
  endtask

  initial begin
    sb       = new();
    rst      = 1'b1;
    in_valid = 1'b0;
    value    = '0;
    last     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    dir_q = '{ValMax};
    send_dir_list();
    dir_q = '{ValMin};
    send_dir_list();
    dir_q = '{32'sd5, 32'sd5, 32'sd5, -32'sd5, 32'sd5};
    send_dir_list();
    dir_q = '{ValMax, ValMin, ValMax, 32'sd0, -32'sd1, ValMax};
    send_dir_list();
    dir_q = '{32'sd3, 32'sd2, 32'sd1, 32'sd0};
    send_dir_list();
    dir_q = '{32'sh5555_5555, 32'shAAAA_AAAA};
    send_dir_list();
    wait_drain();

    hold_req = 1'b1;
    run_phase(0, 0, 1'b1);
    run_phase(70, 0, 1'b0);
    run_phase(0, 70, 1'b0);
    run_phase(23, 23, 1'b0);

    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("stable_sort_with_indices_unit: match");
    end else begin
      $display("stable_sort_with_indices_unit: mismatch");
    end
    $finish;
  end

endmodule
